// ----- hdl/cts_pkg.sv -----
// ----------------------------------------------------------------------------
// cts_pkg
// Shared constants, types and helpers for the centre-and-tile spike encoder.
// ----------------------------------------------------------------------------
package cts_pkg;

   localparam int SIDE         = 28;
   localparam int HALF         = 14;
   localparam int NPIX         = SIDE * SIDE;
   localparam int CELL_ROWS    = 6;
   localparam int CELL_COLS    = 8;
   localparam int SCALE        = NPIX * 10;
   localparam int MASK_W       = 48;
   localparam int MASK_IDX_W   = $clog2(MASK_W);
   localparam int ROW_IDX_W    = (CELL_ROWS > 1) ? $clog2(CELL_ROWS) : 1;
   localparam int COL_IDX_W    = (CELL_COLS > 1) ? $clog2(CELL_COLS) : 1;
   localparam int ADDR_W       = $clog2(NPIX);
   localparam int TOTAL_W      = 18;   // 784 * 255 fits
   // largest cell of the grid, in pixels
   localparam int CELL_H_MAX   = (HALF + CELL_ROWS - 1) / CELL_ROWS;
   localparam int CELL_W_MAX   = (HALF + CELL_COLS - 1) / CELL_COLS;
   localparam int CELL_PIX_MAX = CELL_H_MAX * CELL_W_MAX;
   localparam int SUM_W        = $clog2(CELL_PIX_MAX * 255 + 1);
   localparam int CNT_W        = $clog2(CELL_PIX_MAX + 1);
   localparam int RATIO_W      = 6;
   localparam int PROD_W       = TOTAL_W + RATIO_W;
   localparam int CMP_W        = PROD_W + CNT_W;

   // register indexes
   localparam logic [1:0] CSR_INK_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_LOW_RATIO     = 2'd1;
   localparam logic [1:0] CSR_HIGH_RATIO    = 2'd2;

   localparam logic [1:0] LAST_TILE = 2'd3;

   typedef struct packed {
      logic [4:0]        min_row;
      logic [4:0]        max_row;
      logic [4:0]        min_col;
      logic [4:0]        max_col;
      logic              ink;
      logic signed [2:0] shift_x;
      logic signed [2:0] shift_y;
   } job_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } wr_type;

   typedef struct packed {
      logic busy;
      logic release_frame;
   } back_stat_type;

   // cell row of a quadrant row: the largest i with i * HALF <= r * CELL_ROWS
   function automatic logic [ROW_IDX_W-1:0] cell_row_of(input logic [3:0] r);
      logic [ROW_IDX_W-1:0] j;
      j = '0;
      for (int i = 1; i < CELL_ROWS; i++) begin
         if (int'(r) * CELL_ROWS >= i * HALF) begin
            j = ROW_IDX_W'(i);
         end
      end
      return j;
   endfunction

   function automatic logic [COL_IDX_W-1:0] cell_col_of(input logic [3:0] c);
      logic [COL_IDX_W-1:0] j;
      j = '0;
      for (int i = 1; i < CELL_COLS; i++) begin
         if (int'(c) * CELL_COLS >= i * HALF) begin
            j = COL_IDX_W'(i);
         end
      end
      return j;
   endfunction

endpackage

// ----- hdl/cts_front.sv -----
// ----------------------------------------------------------------------------
// cts_front
// Pixel loader: writes the frame store, tracks the ink bounding box and
// hands one job per image to the back end.
// ----------------------------------------------------------------------------
module cts_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_pixel,
   input  logic signed [2:0]       req_shift_x,
   input  logic signed [2:0]       req_shift_y,
   input  logic [7:0]              ink_threshold,
   input  logic                    release_frame,
   output cts_pkg::wr_type         wr,
   output logic                    job_push,
   output cts_pkg::job_type        job
);

   logic [4:0]                 row_ff, row_in, col_ff, col_in;
   logic [cts_pkg::ADDR_W-1:0] pos_ff, pos_in;
   logic [4:0]                 min_r_ff, min_r_in, max_r_ff, max_r_in;
   logic [4:0]                 min_c_ff, min_c_in, max_c_ff, max_c_in;
   logic                       ink_ff, ink_in;
   logic signed [2:0]          sx_ff, sx_in, sy_ff, sy_in;
   logic                       lock_ff, lock_in;
   logic                       acc, is_ink, end_img;
   logic [4:0]                 bmin_r, bmax_r, bmin_c, bmax_c;

   assign req_ready = !lock_ff;
   assign acc       = req_valid && req_ready;
   assign is_ink    = req_pixel > ink_threshold;
   assign end_img   = (row_ff == 5'(cts_pkg::SIDE - 1)) && (col_ff == 5'(cts_pkg::SIDE - 1));

   always_comb begin
      bmin_r = (is_ink && row_ff < min_r_ff) ? row_ff : min_r_ff;
      bmax_r = (is_ink && row_ff > max_r_ff) ? row_ff : max_r_ff;
      bmin_c = (is_ink && col_ff < min_c_ff) ? col_ff : min_c_ff;
      bmax_c = (is_ink && col_ff > max_c_ff) ? col_ff : max_c_ff;
   end

   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      pos_in   = pos_ff;
      min_r_in = min_r_ff;
      max_r_in = max_r_ff;
      min_c_in = min_c_ff;
      max_c_in = max_c_ff;
      ink_in   = ink_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      lock_in  = lock_ff;
      if (release_frame) begin
         lock_in = 1'b0;
      end
      if (acc) begin
         if (end_img) begin
            // image complete: hand it over and hold off until the back end frees the store
            row_in   = '0;
            col_in   = '0;
            pos_in   = '0;
            min_r_in = 5'(cts_pkg::SIDE);
            min_c_in = 5'(cts_pkg::SIDE);
            max_r_in = '0;
            max_c_in = '0;
            ink_in   = 1'b0;
            sx_in    = '0;
            sy_in    = '0;
            lock_in  = 1'b1;
         end else begin
            pos_in   = pos_ff + 1'b1;
            if (col_ff == 5'(cts_pkg::SIDE - 1)) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
            min_r_in = bmin_r;
            max_r_in = bmax_r;
            min_c_in = bmin_c;
            max_c_in = bmax_c;
            ink_in   = ink_ff || is_ink;
            if (pos_ff == '0) begin
               sx_in = req_shift_x;
               sy_in = req_shift_y;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         pos_ff   <= '0;
         min_r_ff <= 5'(cts_pkg::SIDE);
         min_c_ff <= 5'(cts_pkg::SIDE);
         max_r_ff <= '0;
         max_c_ff <= '0;
         ink_ff   <= 1'b0;
         sx_ff    <= '0;
         sy_ff    <= '0;
         lock_ff  <= 1'b0;
      end else begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         pos_ff   <= pos_in;
         min_r_ff <= min_r_in;
         min_c_ff <= min_c_in;
         max_r_ff <= max_r_in;
         max_c_ff <= max_c_in;
         ink_ff   <= ink_in;
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         lock_ff  <= lock_in;
      end
   end

   always_comb begin
      wr.en        = acc;
      wr.addr      = pos_ff;
      wr.data      = req_pixel;
      job_push     = acc && end_img;
      job.min_row  = bmin_r;
      job.max_row  = bmax_r;
      job.min_col  = bmin_c;
      job.max_col  = bmax_c;
      job.ink      = ink_ff || is_ink;
      job.shift_x  = sx_ff;
      job.shift_y  = sy_ff;
   end

endmodule

// ----- hdl/cts_job_fifo.sv -----
// ----------------------------------------------------------------------------
// cts_job_fifo
// Two-entry queue of image jobs between the loader and the back end.
// ----------------------------------------------------------------------------
module cts_job_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cts_pkg::job_type  push_data,
   input  logic              pop,
   output logic              head_valid,
   output cts_pkg::job_type  head,
   output logic              full
);

   cts_pkg::job_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/cts_back.sv -----
// ----------------------------------------------------------------------------
// cts_back
// Frame store and encoder: sums the centred image, then walks each quadrant
// one grid row at a time and tests its cells against the image mean.
// ----------------------------------------------------------------------------
module cts_back (
   input  logic                          clock,
   input  logic                          reset,
   input  cts_pkg::wr_type               wr,
   input  logic                          job_valid,
   input  cts_pkg::job_type              job,
   output logic                          job_pop,
   input  logic [cts_pkg::RATIO_W-1:0]   low_ratio,
   input  logic [cts_pkg::RATIO_W-1:0]   high_ratio,
   output cts_pkg::back_stat_type        stat,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_quadrant,
   output logic [cts_pkg::MASK_W-1:0]    rsp_low_mask,
   output logic [cts_pkg::MASK_W-1:0]    rsp_high_mask,
   output logic                          rsp_last
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_TOTAL, ST_TDRAIN, ST_PROD, ST_WALK, ST_WDRAIN, ST_CMP, ST_EMIT
   } state_type;

   localparam int CW = cts_pkg::COL_IDX_W;
   localparam int RW = cts_pkg::ROW_IDX_W;
   localparam int MW = cts_pkg::MASK_IDX_W;

   logic [7:0] mem [cts_pkg::NPIX];
   logic [7:0] mem_q_ff;

   state_type                    state_ff, state_in;
   logic signed [5:0]            rs_ff, rs_in, cs_ff, cs_in;
   logic [4:0]                   tr_ff, tr_in, tc_ff, tc_in;
   logic [1:0]                   q_ff, q_in;
   logic [3:0]                   r_ff, r_in, c_ff, c_in;
   logic [RW-1:0]                grow_ff, grow_in;
   logic                         qend_ff, qend_in;
   logic [CW-1:0]                k_ff, k_in;
   logic [cts_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic [cts_pkg::PROD_W-1:0]   tl_ff, tl_in, th_ff, th_in;
   logic [cts_pkg::SUM_W-1:0]    sum_ff [cts_pkg::CELL_COLS];
   logic [cts_pkg::SUM_W-1:0]    sum_in [cts_pkg::CELL_COLS];
   logic [cts_pkg::CNT_W-1:0]    cnt_ff [cts_pkg::CELL_COLS];
   logic [cts_pkg::CNT_W-1:0]    cnt_in [cts_pkg::CELL_COLS];
   logic [cts_pkg::MASK_W-1:0]   lo_ff, lo_in, hi_ff, hi_in;
   logic                         rd_vld_ff, rd_tot_ff, rd_in_ff;
   logic [CW-1:0]                rd_col_ff;
   logic                         ov_ff, ov_in, olast_ff, olast_in;
   logic [1:0]                   otile_ff, otile_in;
   logic [cts_pkg::MASK_W-1:0]   olo_ff, olo_in, ohi_ff, ohi_in;
   logic                         rel_in;

   // issue side
   logic                         issue;
   logic [4:0]                   tr_sel, tc_sel;
   logic signed [6:0]            sr, sc;
   logic                         in_range;
   logic [cts_pkg::ADDR_W-1:0]   rd_addr;
   logic [7:0]                   px;
   logic signed [6:0]            dr, dc, hr, hc;
   logic [cts_pkg::CMP_W-1:0]    lhs, rl, rh;
   logic [MW-1:0]                bit_idx;
   logic                         out_free;

   assign issue  = (state_ff == ST_TOTAL) || (state_ff == ST_WALK);
   assign tr_sel = (state_ff == ST_TOTAL) ? tr_ff
                   : (q_ff[1] ? 5'(cts_pkg::HALF) : 5'd0) + 5'(r_ff);
   assign tc_sel = (state_ff == ST_TOTAL) ? tc_ff
                   : (q_ff[0] ? 5'(cts_pkg::HALF) : 5'd0) + 5'(c_ff);
   assign sr       = signed'({2'b00, tr_sel}) - 7'(rs_ff);
   assign sc       = signed'({2'b00, tc_sel}) - 7'(cs_ff);
   assign in_range = !sr[6] && (sr[5:0] < 6'(cts_pkg::SIDE))
                     && !sc[6] && (sc[5:0] < 6'(cts_pkg::SIDE));
   assign rd_addr  = cts_pkg::ADDR_W'(sr[4:0]) * cts_pkg::ADDR_W'(cts_pkg::SIDE)
                     + cts_pkg::ADDR_W'(sc[4:0]);
   assign px       = rd_in_ff ? mem_q_ff : 8'd0;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      mem_q_ff <= mem[rd_addr];
   end

   // centring shift, truncated toward zero
   always_comb begin
      dr = 7'sd27 - signed'({2'b00, job.min_row}) - signed'({2'b00, job.max_row});
      dc = 7'sd27 - signed'({2'b00, job.min_col}) - signed'({2'b00, job.max_col});
      hr = (dr + (dr[6] ? 7'sd1 : 7'sd0)) >>> 1;
      hc = (dc + (dc[6] ? 7'sd1 : 7'sd0)) >>> 1;
   end

   always_comb begin
      lhs     = cts_pkg::CMP_W'(sum_ff[k_ff]) * cts_pkg::CMP_W'(cts_pkg::SCALE);
      rl      = cts_pkg::CMP_W'(cnt_ff[k_ff]) * cts_pkg::CMP_W'(tl_ff);
      rh      = cts_pkg::CMP_W'(cnt_ff[k_ff]) * cts_pkg::CMP_W'(th_ff);
      bit_idx = MW'(grow_ff) * MW'(cts_pkg::CELL_COLS) + MW'(k_ff);
   end

   assign out_free = !ov_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      rs_in    = rs_ff;
      cs_in    = cs_ff;
      tr_in    = tr_ff;
      tc_in    = tc_ff;
      q_in     = q_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      grow_in  = grow_ff;
      qend_in  = qend_ff;
      k_in     = k_ff;
      total_in = total_ff;
      tl_in    = tl_ff;
      th_in    = th_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      sum_in   = sum_ff;
      cnt_in   = cnt_ff;
      ov_in    = ov_ff && !rsp_ready;
      otile_in = otile_ff;
      olo_in   = olo_ff;
      ohi_in   = ohi_ff;
      olast_in = olast_ff;
      rel_in   = 1'b0;
      job_pop  = 1'b0;

      // accumulate the word read in the previous cycle
      if (rd_vld_ff) begin
         if (rd_tot_ff) begin
            total_in = total_ff + cts_pkg::TOTAL_W'(px);
         end else begin
            sum_in[rd_col_ff] = sum_ff[rd_col_ff] + cts_pkg::SUM_W'(px);
            cnt_in[rd_col_ff] = cnt_ff[rd_col_ff] + 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               rs_in    = job.ink ? 6'(hr + 7'(job.shift_y)) : 6'sd0;
               cs_in    = job.ink ? 6'(hc + 7'(job.shift_x)) : 6'sd0;
               tr_in    = '0;
               tc_in    = '0;
               total_in = '0;
               state_in = ST_TOTAL;
            end
         end
         ST_TOTAL: begin
            if (tc_ff == 5'(cts_pkg::SIDE - 1)) begin
               tc_in = '0;
               if (tr_ff == 5'(cts_pkg::SIDE - 1)) begin
                  tr_in    = '0;
                  state_in = ST_TDRAIN;
               end else begin
                  tr_in = tr_ff + 1'b1;
               end
            end else begin
               tc_in = tc_ff + 1'b1;
            end
         end
         ST_TDRAIN: begin
            state_in = ST_PROD;
         end
         ST_PROD: begin
            tl_in = cts_pkg::PROD_W'(total_ff) * cts_pkg::PROD_W'(low_ratio);
            th_in = cts_pkg::PROD_W'(total_ff) * cts_pkg::PROD_W'(high_ratio);
            for (int i = 0; i < cts_pkg::CELL_COLS; i++) begin
               sum_in[i] = '0;
               cnt_in[i] = '0;
            end
            lo_in    = '0;
            hi_in    = '0;
            q_in     = '0;
            r_in     = '0;
            c_in     = '0;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            grow_in = cts_pkg::cell_row_of(r_ff);
            if (c_ff == 4'(cts_pkg::HALF - 1)) begin
               c_in = '0;
               if (r_ff == 4'(cts_pkg::HALF - 1)) begin
                  r_in     = '0;
                  qend_in  = 1'b1;
                  state_in = ST_WDRAIN;
               end else begin
                  r_in = r_ff + 1'b1;
                  if (cts_pkg::cell_row_of(r_ff + 1'b1) != cts_pkg::cell_row_of(r_ff)) begin
                     qend_in  = 1'b0;
                     state_in = ST_WDRAIN;
                  end
               end
            end else begin
               c_in = c_ff + 1'b1;
            end
         end
         ST_WDRAIN: begin
            k_in     = '0;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (sum_ff[k_ff] != '0) begin
               if (lhs >= rl) lo_in[bit_idx] = 1'b1;
               if (lhs >= rh) hi_in[bit_idx] = 1'b1;
            end
            if (k_ff == CW'(cts_pkg::CELL_COLS - 1)) begin
               for (int i = 0; i < cts_pkg::CELL_COLS; i++) begin
                  sum_in[i] = '0;
                  cnt_in[i] = '0;
               end
               state_in = qend_ff ? ST_EMIT : ST_WALK;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               ov_in    = 1'b1;
               otile_in = q_ff;
               olo_in   = lo_ff;
               ohi_in   = hi_ff;
               olast_in = q_ff == cts_pkg::LAST_TILE;
               lo_in    = '0;
               hi_in    = '0;
               if (q_ff == cts_pkg::LAST_TILE) begin
                  rel_in   = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  q_in     = q_ff + 1'b1;
                  state_in = ST_WALK;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_vld_ff <= 1'b0;
         ov_ff     <= 1'b0;
         stat      <= '0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= issue;
         ov_ff     <= ov_in;
         stat.busy          <= state_in != ST_IDLE;
         stat.release_frame <= rel_in;
      end
      rs_ff     <= rs_in;
      cs_ff     <= cs_in;
      tr_ff     <= tr_in;
      tc_ff     <= tc_in;
      q_ff      <= q_in;
      r_ff      <= r_in;
      c_ff      <= c_in;
      grow_ff   <= grow_in;
      qend_ff   <= qend_in;
      k_ff      <= k_in;
      total_ff  <= total_in;
      tl_ff     <= tl_in;
      th_ff     <= th_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      sum_ff    <= sum_in;
      cnt_ff    <= cnt_in;
      rd_tot_ff <= state_ff == ST_TOTAL;
      rd_in_ff  <= in_range;
      rd_col_ff <= cts_pkg::cell_col_of(c_ff);
      otile_ff  <= otile_in;
      olo_ff    <= olo_in;
      ohi_ff    <= ohi_in;
      olast_ff  <= olast_in;
   end

   assign rsp_valid      = ov_ff;
   assign rsp_quadrant   = otile_ff;
   assign rsp_low_mask   = olo_ff;
   assign rsp_high_mask  = ohi_ff;
   assign rsp_last       = olast_ff;

endmodule

// ----- hdl/center_and_tile_spike_encoder.sv -----
// ----------------------------------------------------------------------------
// center_and_tile_spike_encoder
// Loads a 28x28 image, centres its ink box and emits four quadrant cell masks.
// ----------------------------------------------------------------------------
// Pixels load one per cycle while req_ready is high, 784 to an image. After its
// last pixel the input holds ready low while the encoder reads the frame store:
// it sums the whole centred image, drains the last read, forms the threshold
// products, then walks each quadrant with 196 reads, a drain and eight cell
// compares after each of the six grid rows, and a step to hand the word over,
// which may wait on the result side. Four result words follow each image; last
// marks the fourth.
module center_and_tile_spike_encoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_pixel,
   input  logic signed [2:0]             req_shift_x,
   input  logic signed [2:0]             req_shift_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_quadrant,
   output logic [cts_pkg::MASK_W-1:0]    rsp_low_mask,
   output logic [cts_pkg::MASK_W-1:0]    rsp_high_mask,
   output logic                          rsp_last,
   input  logic                          csr_write_enable,
   input  logic [1:0]                    csr_index,
   input  logic [7:0]                    csr_write_data
);

   logic [7:0]                   ink_thr_ff;
   logic [cts_pkg::RATIO_W-1:0]  low_ratio_ff, high_ratio_ff;
   cts_pkg::wr_type              wr;
   cts_pkg::job_type             job, head;
   cts_pkg::back_stat_type       stat;
   logic                         job_push, job_pop, head_valid, fifo_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         ink_thr_ff    <= 8'd20;
         low_ratio_ff  <= 6'd7;
         high_ratio_ff <= 6'd14;
      end else if (csr_write_enable) begin
         case (csr_index)
            cts_pkg::CSR_INK_THRESHOLD: ink_thr_ff    <= csr_write_data;
            cts_pkg::CSR_LOW_RATIO:     low_ratio_ff  <= csr_write_data[5:0];
            cts_pkg::CSR_HIGH_RATIO:    high_ratio_ff <= csr_write_data[5:0];
            default: ;
         endcase
      end
   end

   cts_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pixel     (req_pixel),
      .req_shift_x   (req_shift_x),
      .req_shift_y   (req_shift_y),
      .ink_threshold (ink_thr_ff),
      .release_frame (stat.release_frame),
      .wr            (wr),
      .job_push      (job_push),
      .job           (job)
   );

   cts_job_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_data  (job),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head       (head),
      .full       (fifo_full)
   );

   cts_back u_back (
      .clock          (clock),
      .reset          (reset),
      .wr             (wr),
      .job_valid      (head_valid),
      .job            (head),
      .job_pop        (job_pop),
      .low_ratio      (low_ratio_ff),
      .high_ratio     (high_ratio_ff),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_quadrant   (rsp_quadrant),
      .rsp_low_mask   (rsp_low_mask),
      .rsp_high_mask  (rsp_high_mask),
      .rsp_last       (rsp_last)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !fifo_full)
      else $error("job queue overflow");

   a_store_owned: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !stat.busy)
      else $error("pixel written while the frame store is being read");

   a_last_tile: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_quadrant == cts_pkg::LAST_TILE))
      else $error("last flag on wrong quadrant");

   a_release: assert property (@(posedge clock) disable iff (reset)
      stat.release_frame |-> (rsp_valid && rsp_last))
      else $error("frame released before final word");

endmodule

// ----- test/center_and_tile_spike_encoder_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// center_and_tile_spike_encoder_test
// Self-checking bench: streams whole images through the encoder and compares
// every quadrant word with a local model of centring and cell thresholding or
// with table masks. A short table of directed images comes first, then random
// inked images under changing thresholds, with random idling on both sides.
// ----------------------------------------------------------------------------
module center_and_tile_spike_encoder_test;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 20;
   localparam int NCELLS      = cts_pkg::CELL_ROWS * cts_pkg::CELL_COLS;
   localparam logic [1:0] CSR_SPARE = 2'd3;

   typedef enum int {PAT_BLANK, PAT_FLAT, PAT_DOT, PAT_NOISE, PAT_BOX} pattern_type;

   typedef struct {
      pattern_type                pattern;
      logic [7:0]                 level;
      int                         r0, c0, r1, c1;
      logic signed [2:0]          sx, sy;
      logic [7:0]                 thr;
      logic [5:0]                 lo_ratio, hi_ratio;
      bit                         typed;
      logic [cts_pkg::MASK_W-1:0] want_lo, want_hi;
   } image_row_type;

   typedef struct {
      logic [1:0]                 tile;
      logic [cts_pkg::MASK_W-1:0] lo, hi;
      logic                       last;
   } tile_word_type;

   localparam logic [cts_pkg::MASK_W-1:0] ALL_CELLS = cts_pkg::MASK_W'({NCELLS{1'b1}});

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready;
   logic [7:0] req_pixel = 0;
   logic signed [2:0] req_shift_x = 0, req_shift_y = 0;
   logic rsp_valid, rsp_ready = 0;
   logic [1:0] rsp_quadrant;
   logic [cts_pkg::MASK_W-1:0] rsp_low_mask, rsp_high_mask;
   logic rsp_last;
   logic csr_write_enable = 0;
   logic [1:0] csr_index = 0;
   logic [7:0] csr_write_data = 0;

   logic [7:0]     image_buf [cts_pkg::NPIX];
   tile_word_type  pending_tiles [$];
   logic [7:0]     ink_thr;
   logic [5:0]     lo_tenths, hi_tenths;
   int             errors = 0;
   int             cycles = 0;
   int             long_hold = 0;
   bit             no_idle = 0;

   center_and_tile_spike_encoder dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Centre the ink box, cut each quadrant into cells, threshold against mean.
   function automatic void predict_tiles(input logic signed [2:0] sx,
                                         input logic signed [2:0] sy);
      logic [7:0]       moved [cts_pkg::NPIX];
      longint unsigned  sums [NCELLS];
      longint unsigned  cnts [NCELLS];
      longint unsigned  total, lhs;
      int               min_r, min_c, max_r, max_c, dr, dc, tr, tc, k;
      bit               ink;
      tile_word_type    w;
      min_r = cts_pkg::SIDE; min_c = cts_pkg::SIDE; max_r = 0; max_c = 0; ink = 0;
      for (int p = 0; p < cts_pkg::NPIX; p++) begin
         if (image_buf[p] > ink_thr) begin
            ink = 1;
            if (p / cts_pkg::SIDE < min_r) min_r = p / cts_pkg::SIDE;
            if (p / cts_pkg::SIDE > max_r) max_r = p / cts_pkg::SIDE;
            if (p % cts_pkg::SIDE < min_c) min_c = p % cts_pkg::SIDE;
            if (p % cts_pkg::SIDE > max_c) max_c = p % cts_pkg::SIDE;
         end
      end
      if (ink) begin
         dr = (cts_pkg::SIDE - 1 - min_r - max_r) / 2 + int'(sy);
         dc = (cts_pkg::SIDE - 1 - min_c - max_c) / 2 + int'(sx);
         for (int p = 0; p < cts_pkg::NPIX; p++) moved[p] = 0;
         for (int r = 0; r < cts_pkg::SIDE; r++)
            for (int c = 0; c < cts_pkg::SIDE; c++) begin
               tr = r + dr;
               tc = c + dc;
               if (tr >= 0 && tr < cts_pkg::SIDE && tc >= 0 && tc < cts_pkg::SIDE)
                  moved[tr*cts_pkg::SIDE + tc] = image_buf[r*cts_pkg::SIDE + c];
            end
      end else begin
         for (int p = 0; p < cts_pkg::NPIX; p++) moved[p] = image_buf[p];
      end
      total = 0;
      for (int p = 0; p < cts_pkg::NPIX; p++) total += moved[p];
      for (int q = 0; q < 4; q++) begin
         for (k = 0; k < NCELLS; k++) begin
            sums[k] = 0;
            cnts[k] = 0;
         end
         for (int r = 0; r < cts_pkg::HALF; r++)
            for (int c = 0; c < cts_pkg::HALF; c++) begin
               k = (r * cts_pkg::CELL_ROWS / cts_pkg::HALF) * cts_pkg::CELL_COLS
                   + c * cts_pkg::CELL_COLS / cts_pkg::HALF;
               sums[k] += moved[((q/2)*cts_pkg::HALF + r)*cts_pkg::SIDE
                                + (q%2)*cts_pkg::HALF + c];
               cnts[k]++;
            end
         w.tile = q[1:0];
         w.lo = 0;
         w.hi = 0;
         w.last = (q == 3);
         for (k = 0; k < NCELLS; k++) begin
            lhs = sums[k] * cts_pkg::NPIX * 10;
            if (sums[k] != 0) begin
               if (lhs >= total * cnts[k] * lo_tenths) w.lo[k] = 1'b1;
               if (lhs >= total * cnts[k] * hi_tenths) w.hi[k] = 1'b1;
            end
         end
         pending_tiles.push_back(w);
      end
   endfunction

   function automatic void push_typed(input logic [cts_pkg::MASK_W-1:0] lo,
                                      input logic [cts_pkg::MASK_W-1:0] hi);
      tile_word_type w;
      for (int q = 0; q < 4; q++) begin
         w.tile = q[1:0];
         w.lo = lo;
         w.hi = hi;
         w.last = (q == 3);
         pending_tiles.push_back(w);
      end
   endfunction

   function automatic void fill_image(input image_row_type row);
      int r, c;
      for (int p = 0; p < cts_pkg::NPIX; p++) begin
         r = p / cts_pkg::SIDE;
         c = p % cts_pkg::SIDE;
         case (row.pattern)
            PAT_BLANK: image_buf[p] = 0;
            PAT_FLAT:  image_buf[p] = row.level;
            PAT_DOT:   image_buf[p] = (r == row.r0 && c == row.c0) ? row.level : 8'd0;
            PAT_NOISE: image_buf[p] = 8'($urandom_range(0, row.level));
            PAT_BOX: begin
               if (r >= row.r0 && r <= row.r1 && c >= row.c0 && c <= row.c1)
                  image_buf[p] = 8'($urandom_range(0, row.level));
               else
                  image_buf[p] = 8'($urandom_range(0, 8));
            end
            default: image_buf[p] = 0;
         endcase
      end
   endfunction

   // Hold the enable high across the writes; the caller drops it afterwards.
   task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         cts_pkg::CSR_INK_THRESHOLD: ink_thr   = data;
         cts_pkg::CSR_LOW_RATIO:     lo_tenths = data[5:0];
         cts_pkg::CSR_HIGH_RATIO:    hi_tenths = data[5:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [7:0] thr, input logic [5:0] lo,
                            input logic [5:0] hi);
      write_reg(cts_pkg::CSR_INK_THRESHOLD, thr);
      write_reg(cts_pkg::CSR_LOW_RATIO, 8'(lo));
      write_reg(cts_pkg::CSR_HIGH_RATIO, 8'(hi));
      csr_write_enable <= 1'b0;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_tiles.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Leave valid as it is after the last word; the caller lowers it when pausing.
   task automatic send_image(input logic signed [2:0] sx, input logic signed [2:0] sy,
                             input bit typed, input logic [cts_pkg::MASK_W-1:0] lo,
                             input logic [cts_pkg::MASK_W-1:0] hi);
      int gap;
      for (int p = 0; p < cts_pkg::NPIX; p++) begin
         gap = no_idle ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid   <= 1'b1;
         req_pixel   <= image_buf[p];
         req_shift_x <= (p == 0) ? sx : 3'($urandom_range(0, 7));
         req_shift_y <= (p == 0) ? sy : 3'($urandom_range(0, 7));
         do @(posedge clock); while (!req_ready);
      end
      if (typed) push_typed(lo, hi);
      else predict_tiles(sx, sy);
   endtask

   always @(posedge clock) begin
      int            stall;
      tile_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_tiles.size() == 0) begin
               $display("%0t: word expected none actual tile %0d", $time, rsp_quadrant);
               errors++;
            end else begin
               want = pending_tiles.pop_front();
               if (rsp_quadrant !== want.tile) begin
                  $display("%0t: quadrant expected %0d actual %0d",
                           $time, want.tile, rsp_quadrant);
                  errors++;
               end
               if (rsp_low_mask !== want.lo) begin
                  $display("%0t: low_mask expected %h actual %h",
                           $time, want.lo, rsp_low_mask);
                  errors++;
               end
               if (rsp_high_mask !== want.hi) begin
                  $display("%0t: high_mask expected %h actual %h",
                           $time, want.hi, rsp_high_mask);
                  errors++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last expected %0d actual %0d",
                           $time, want.last, rsp_last);
                  errors++;
               end
            end
            stall = no_idle ? 0 : $urandom_range(0, 5);
         end
         if (long_hold > 0) begin
            stall = long_hold;
            long_hold = 0;
         end
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   image_row_type directed [9] = '{
      '{PAT_BLANK, 8'd0,   0, 0, 0, 0, 3'sd3, 3'sd3, 8'd20, 6'd7, 6'd14, 1, 0, 0},
      '{PAT_FLAT, 8'd255,  0, 0, 0, 0, 3'sd0, 3'sd0, 8'd20, 6'd7, 6'd14, 1, ALL_CELLS, 0},
      '{PAT_FLAT, 8'd255,  0, 0, 0, 0, 3'sd0, 3'sd0, 8'd20, 6'd0, 6'd40, 1, ALL_CELLS, 0},
      '{PAT_DOT, 8'd255,   0, 0, 0, 0, -3'sd3, -3'sd3, 8'd20, 6'd7, 6'd14, 0, 0, 0},
      '{PAT_DOT, 8'd1,   27, 27, 0, 0, 3'sd3, 3'sd3, 8'd0, 6'd7, 6'd14, 0, 0, 0},
      '{PAT_NOISE, 8'd20,  0, 0, 0, 0, 3'sd3, -3'sd3, 8'd20, 6'd7, 6'd14, 0, 0, 0},
      '{PAT_NOISE, 8'd255, 0, 0, 0, 0, -3'sd3, 3'sd3, 8'd255, 6'd10, 6'd10, 0, 0, 0},
      '{PAT_BOX, 8'd200,   3, 5, 10, 20, -3'sd1, 3'sd2, 8'd100, 6'd40, 6'd0, 0, 0, 0},
      '{PAT_BOX, 8'd255,  20, 0, 27, 9, 3'sd0, 3'sd0, 8'd0, 6'd14, 6'd28, 0, 0, 0}
   };

   initial begin
      image_row_type row;
      ink_thr = 8'd20;
      lo_tenths = 6'd7;
      hi_tenths = 6'd14;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_reg(CSR_SPARE, 8'hFF);
      csr_write_enable <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         row = directed[i];
         configure(row.thr, row.lo_ratio, row.hi_ratio);
         no_idle = (i % 3 == 2);
         fill_image(row);
         send_image(row.sx, row.sy, row.typed, row.want_lo, row.want_hi);
         drain();
      end

      for (int k = 0; k < 12; k++) begin
         row.pattern = ($urandom_range(0, 9) == 0) ? PAT_NOISE : PAT_BOX;
         row.level = 8'($urandom_range(40, 255));
         row.r0 = $urandom_range(0, 27);
         row.c0 = $urandom_range(0, 27);
         row.r1 = $urandom_range(row.r0, row.r0 + 14 > 27 ? 27 : row.r0 + 14);
         row.c1 = $urandom_range(row.c0, row.c0 + 14 > 27 ? 27 : row.c0 + 14);
         if (k % 3 == 0) begin
            drain();
            case ($urandom_range(0, 3))
               0: configure(8'd0, 6'd0, 6'd40);
               1: configure(8'd255, 6'd40, 6'd0);
               default: configure(8'($urandom_range(9, 60)), 6'($urandom_range(0, 40)),
                                  6'($urandom_range(0, 40)));
            endcase
         end
         // Starve the result side for a long stretch while the next image waits at the input.
         if (k == 1) long_hold = 4000;
         no_idle = ($urandom_range(0, 3) == 0);
         fill_image(row);
         send_image(3'($urandom_range(0, 6) - 3), 3'($urandom_range(0, 6) - 3), 0, 0, 0);
      end

      req_valid <= 1'b0;
      while (pending_tiles.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0 && pending_tiles.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
